// File: rtl/replicated_log_store_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the replicated log store
// Shared clocked property wrappers, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef REPLICATED_LOG_STORE_ASSERT_SVH
`define REPLICATED_LOG_STORE_ASSERT_SVH

// Same-cycle implication.
`define RLS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rls_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rls_pkg
// Request and response types, operation and status codes, sequencer states.
// ---------------------------------------------------------------------------
package rls_pkg;

	localparam int IDX_W = 11;

	typedef struct packed {
		logic [2:0]       mode;
		logic [IDX_W-1:0] position;
		logic [IDX_W-1:0] element_index;
		logic [31:0]      term_in;
		logic [63:0]      payload_in;
		logic             batch_last;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [IDX_W-1:0] hint_index;
		logic [31:0]      term_out;
		logic [63:0]      payload_out;
		logic [IDX_W-1:0] last_index;
		logic [31:0]      last_term;
	} rsp_t;

	localparam logic [2:0] MODE_APPEND = 3'd0;
	localparam logic [2:0] MODE_BATCH  = 3'd1;
	localparam logic [2:0] MODE_READ   = 3'd2;
	localparam logic [2:0] MODE_CHECK  = 3'd3;
	localparam logic [2:0] MODE_TRUNC  = 3'd4;

	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_STAGED   = 3'd1;
	localparam logic [2:0] STS_RANGE    = 3'd2;
	localparam logic [2:0] STS_GAP      = 3'd3;
	localparam logic [2:0] STS_FULL     = 3'd4;
	localparam logic [2:0] STS_MISMATCH = 3'd5;

	typedef enum logic [1:0] {
		BERR_NONE,
		BERR_GAP,
		BERR_OVER
	} berr_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_READ_WAIT,
		ST_CHECK_WAIT,
		ST_SCAN_WAIT,
		ST_LAST_WAIT,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/replicated_log_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// replicated_log_store
// Consensus log store: append, batch stage/commit, read, check, truncate.
// ---------------------------------------------------------------------------
// One request is handled at a time by a small sequencer around a simple
// dual-port log memory (one read and one write address per cycle, registered
// read). The request channel stalls from the cycle after acceptance until the
// response is loaded into the output register. An append, a staged batch
// element, a failed commit, a truncate to empty, a check answered from the log
// length alone or any out-of-range request goes from dispatch straight to the
// emit state; a read, a truncate and a consistency check that reads the log
// first wait for the registered log read. A mismatching check then walks back
// over the conflicting term run, one older entry per scan step. A committed
// batch alternates copy-read and copy-write steps, since each element is read
// from the staging memory and then written into the log. While the previous
// response is still held by rsp_stall, the new one waits in the last state.
// The newest entry's term is kept in a register, so last_term needs no log
// read except after a truncate, which re-reads it.
// ---------------------------------------------------------------------------
`include "replicated_log_store_assert.svh"

module replicated_log_store
	import rls_pkg::*;
#(
	parameter int LOG_DEPTH    = 1024,
	parameter int BATCH_MAX    = 64,
	parameter int PAYLOAD_BITS = 64,
	parameter int TERM_BITS    = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW   = $clog2(LOG_DEPTH);
	localparam int LW   = $clog2(LOG_DEPTH + 1);
	localparam int CW   = ((LW > IDX_W) ? LW : IDX_W) + 1;
	localparam int BW   = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
	localparam int CNTW = $clog2(BATCH_MAX + 1);
	localparam int TW   = TERM_BITS;
	localparam int PW   = PAYLOAD_BITS;

	// Sequencer and log control state.
	state_t          state_q, state_d;
	logic [LW-1:0]   len_q, len_d;
	logic [TW-1:0]   last_term_q, last_term_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	logic [CW-1:0]   start_q, start_d;
	berr_t           err_q, err_d;
	logic [CNTW-1:0] ccount_q, ccount_d;
	logic [CNTW-1:0] copy_q, copy_d;
	logic [AW-1:0]   base_q, base_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic [TW-1:0]   mine_q, mine_d;
	logic            rsp_valid_q, rsp_valid_d;

	// Latched request and response being built.
	cmd_t             req_q;
	logic [2:0]       res_status_q, res_status_d;
	logic [IDX_W-1:0] res_hint_q, res_hint_d;
	logic [TW-1:0]    res_term_q, res_term_d;
	logic [PW-1:0]    res_pay_q, res_pay_d;
	rsp_t             rsp_q, rsp_d;
	logic             rsp_load;

	// Log memory.
	logic [TW-1:0] lt_mem [LOG_DEPTH];
	logic [PW-1:0] lp_mem [LOG_DEPTH];
	logic          log_we;
	logic [AW-1:0] log_waddr, log_raddr;
	logic [TW-1:0] log_wterm, log_rterm_q;
	logic [PW-1:0] log_wpay, log_rpay_q;

	// Staging memory.
	logic [TW-1:0] st_mem [BATCH_MAX];
	logic [PW-1:0] sp_mem [BATCH_MAX];
	logic          stg_we;
	logic [BW-1:0] stg_waddr, stg_raddr;
	logic [TW-1:0] stg_rterm_q;
	logic [PW-1:0] stg_rpay_q;

	// Request fields in working widths.
	logic [CW-1:0] pos_c, eidx_c, len_c;
	logic [TW-1:0] term_k;
	logic [PW-1:0] pay_k;
	logic [CW-1:0] start_v;
	berr_t         err_v;
	logic [CNTW-1:0] cnt_v;

	assign pos_c  = CW'(req_q.position);
	assign eidx_c = CW'(req_q.element_index);
	assign len_c  = CW'(len_q);
	assign term_k = TW'(req_q.term_in);
	assign pay_k  = PW'(req_q.payload_in);

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (log_we) begin
			lt_mem[log_waddr] <= log_wterm;
			lp_mem[log_waddr] <= log_wpay;
		end
		log_rterm_q <= lt_mem[log_raddr];
		log_rpay_q  <= lp_mem[log_raddr];
	end

	always_ff @(posedge clk) begin
		if (stg_we) begin
			st_mem[stg_waddr] <= term_k;
			sp_mem[stg_waddr] <= pay_k;
		end
		stg_rterm_q <= st_mem[stg_raddr];
		stg_rpay_q  <= sp_mem[stg_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			last_term_q <= '0;
			cnt_q       <= '0;
			start_q     <= '0;
			err_q       <= BERR_NONE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			len_q       <= len_d;
			last_term_q <= last_term_d;
			cnt_q       <= cnt_d;
			start_q     <= start_d;
			err_q       <= err_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			req_q <= cmd;
		end
		ccount_q     <= ccount_d;
		copy_q       <= copy_d;
		base_q       <= base_d;
		idx_q        <= idx_d;
		mine_q       <= mine_d;
		res_status_q <= res_status_d;
		res_hint_q   <= res_hint_d;
		res_term_q   <= res_term_d;
		res_pay_q    <= res_pay_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		len_d        = len_q;
		last_term_d  = last_term_q;
		cnt_d        = cnt_q;
		start_d      = start_q;
		err_d        = err_q;
		ccount_d     = ccount_q;
		copy_d       = copy_q;
		base_d       = base_q;
		idx_d        = idx_q;
		mine_d       = mine_q;
		res_status_d = res_status_q;
		res_hint_d   = res_hint_q;
		res_term_d   = res_term_q;
		res_pay_d    = res_pay_q;
		rsp_valid_d  = rsp_valid_q && rsp_stall;
		rsp_load     = 1'b0;
		log_we       = 1'b0;
		log_waddr    = AW'(len_q);
		log_wterm    = term_k;
		log_wpay     = pay_k;
		log_raddr    = AW'(pos_c - CW'(1));
		stg_we       = 1'b0;
		stg_waddr    = BW'(cnt_q);
		stg_raddr    = BW'(copy_q);
		start_v      = (cnt_q == '0) ? pos_c : start_q;
		err_v        = (cnt_q == '0) ? BERR_NONE : err_q;
		cnt_v        = cnt_q;

		rsp_d.status      = res_status_q;
		rsp_d.hint_index  = res_hint_q;
		rsp_d.term_out    = 32'(res_term_q);
		rsp_d.payload_out = 64'(res_pay_q);
		rsp_d.last_index  = IDX_W'(len_q);
		rsp_d.last_term   = 32'(last_term_q);

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				res_status_d = STS_RANGE;
				res_hint_d   = '0;
				res_term_d   = '0;
				res_pay_d    = '0;
				state_d      = ST_EMIT;
				unique case (req_q.mode)
					MODE_APPEND: begin
						if (len_c >= CW'(LOG_DEPTH)) begin
							res_status_d = STS_FULL;
						end else begin
							log_we       = 1'b1;
							last_term_d  = term_k;
							len_d        = len_q + LW'(1);
							res_status_d = STS_OK;
						end
					end
					MODE_BATCH: begin
						// Stage the element, or record an overflow when staging is full.
						if (cnt_q < CNTW'(BATCH_MAX)) begin
							stg_we = 1'b1;
							if (eidx_c != start_v + CW'(cnt_q) && err_v == BERR_NONE) begin
								err_v = BERR_GAP;
							end
							cnt_v = cnt_q + CNTW'(1);
						end else if (err_v == BERR_NONE) begin
							err_v = BERR_OVER;
						end
						if (req_q.batch_last) begin
							cnt_d   = '0;
							start_d = '0;
							err_d   = BERR_NONE;
							priority if (start_v == '0 || start_v > len_c + CW'(1)) begin
								res_status_d = STS_RANGE;
							end else if (err_v == BERR_GAP) begin
								res_status_d = STS_GAP;
							end else if (err_v == BERR_OVER) begin
								res_status_d = STS_FULL;
							end else if (start_v - CW'(1) + CW'(cnt_v) > CW'(LOG_DEPTH)) begin
								res_status_d = STS_FULL;
							end else begin
								base_d   = AW'(start_v - CW'(1));
								ccount_d = cnt_v;
								copy_d   = '0;
								state_d  = ST_COPY_RD;
							end
						end else begin
							cnt_d        = cnt_v;
							start_d      = start_v;
							err_d        = err_v;
							res_status_d = STS_STAGED;
						end
					end
					MODE_READ: begin
						if (pos_c != '0 && pos_c <= len_c) begin
							state_d = ST_READ_WAIT;
						end
					end
					MODE_CHECK: begin
						priority if (pos_c == '0) begin
							res_status_d = STS_OK;
						end else if (pos_c > len_c) begin
							res_status_d = STS_MISMATCH;
							res_hint_d   = IDX_W'(len_c + CW'(1));
						end else begin
							idx_d   = pos_c;
							state_d = ST_CHECK_WAIT;
						end
					end
					MODE_TRUNC: begin
						if (pos_c != '0 && pos_c <= len_c) begin
							len_d        = LW'(pos_c - CW'(1));
							res_status_d = STS_OK;
							if (pos_c > CW'(1)) begin
								// Re-read the new newest entry for last_term.
								log_raddr = AW'(pos_c - CW'(2));
								state_d   = ST_LAST_WAIT;
							end else begin
								last_term_d = '0;
							end
						end
					end
					default: begin
						res_status_d = STS_RANGE;
					end
				endcase
			end
			ST_COPY_RD: begin
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				log_we      = 1'b1;
				log_waddr   = base_q + AW'(copy_q);
				log_wterm   = stg_rterm_q;
				log_wpay    = stg_rpay_q;
				last_term_d = stg_rterm_q;
				copy_d      = copy_q + CNTW'(1);
				if (copy_d == ccount_q) begin
					len_d        = LW'(CW'(base_q) + CW'(ccount_q));
					res_status_d = STS_OK;
					state_d      = ST_EMIT;
				end else begin
					state_d = ST_COPY_RD;
				end
			end
			ST_READ_WAIT: begin
				res_term_d   = log_rterm_q;
				res_pay_d    = log_rpay_q;
				res_status_d = STS_OK;
				state_d      = ST_EMIT;
			end
			ST_CHECK_WAIT: begin
				if (log_rterm_q == term_k) begin
					res_status_d = STS_OK;
					state_d      = ST_EMIT;
				end else begin
					mine_d       = log_rterm_q;
					res_status_d = STS_MISMATCH;
					if (idx_q > CW'(1)) begin
						log_raddr = AW'(idx_q - CW'(2));
						state_d   = ST_SCAN_WAIT;
					end else begin
						res_hint_d = IDX_W'(idx_q);
						state_d    = ST_EMIT;
					end
				end
			end
			ST_SCAN_WAIT: begin
				// Walk back while the older entry still carries the conflicting term.
				if (log_rterm_q == mine_q) begin
					idx_d = idx_q - CW'(1);
					if (idx_q > CW'(2)) begin
						log_raddr = AW'(idx_q - CW'(3));
					end else begin
						res_hint_d = IDX_W'(idx_q - CW'(1));
						state_d    = ST_EMIT;
					end
				end else begin
					res_hint_d = IDX_W'(idx_q);
					state_d    = ST_EMIT;
				end
			end
			ST_LAST_WAIT: begin
				last_term_d = log_rterm_q;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				// Load the output register once the previous response has left.
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load    = 1'b1;
					rsp_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`RLS_ASSERT(a_len_bound, 1'b1, len_q <= LW'(LOG_DEPTH), "log length beyond depth")
	`RLS_ASSERT(a_stage_bound, 1'b1, cnt_q <= CNTW'(BATCH_MAX), "staged count beyond batch max")
	`RLS_ASSERT(a_copy_bound, state_q == ST_COPY_WR, copy_q < ccount_q, "copy past batch end")
	`RLS_ASSERT_NEXT(a_accept_dispatch, cmd_valid && !cmd_stall, state_q == ST_DISPATCH, "accepted request not dispatched")

endmodule

// File: sim/replicated_log_store_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// replicated_log_store_tb
// Drives log operations into the store with random idling on both channels
// and compares every response with a software copy of the log.
// ---------------------------------------------------------------------------

// Software copy of the log and FIFO of predicted responses.
class log_scoreboard;
	logic [31:0] terms[1024];
	logic [63:0] payloads[1024];
	int unsigned length;
	logic [31:0] stage_terms[64];
	logic [63:0] stage_payloads[64];
	int unsigned stage_count;
	int unsigned stage_start;
	rls_pkg::berr_t stage_err;
	rls_pkg::rsp_t pending[$];
	int errors;

	function new();
		length = 0;
		stage_count = 0;
		stage_start = 0;
		stage_err = rls_pkg::BERR_NONE;
		errors = 0;
	endfunction

	function logic [2:0] commit();
		if (stage_start == 0 || stage_start > length + 1) return rls_pkg::STS_RANGE;
		if (stage_err == rls_pkg::BERR_GAP) return rls_pkg::STS_GAP;
		if (stage_err == rls_pkg::BERR_OVER) return rls_pkg::STS_FULL;
		if (stage_start - 1 + stage_count > 1024) return rls_pkg::STS_FULL;
		for (int i = 0; i < stage_count; i++) begin
			terms[stage_start - 1 + i] = stage_terms[i];
			payloads[stage_start - 1 + i] = stage_payloads[i];
		end
		length = stage_start - 1 + stage_count;
		return rls_pkg::STS_OK;
	endfunction

	// Note an accepted request and queue its predicted response.
	function void note_request(rls_pkg::cmd_t c);
		rls_pkg::rsp_t r;
		int unsigned idx;
		r = '0;
		r.status = rls_pkg::STS_RANGE;
		case (c.mode)
			rls_pkg::MODE_APPEND: begin
				if (length >= 1024) r.status = rls_pkg::STS_FULL;
				else begin
					terms[length] = c.term_in;
					payloads[length] = c.payload_in;
					length++;
					r.status = rls_pkg::STS_OK;
				end
			end
			rls_pkg::MODE_BATCH: begin
				if (stage_count == 0) begin
					stage_start = 32'(c.position);
					stage_err = rls_pkg::BERR_NONE;
				end
				if (stage_count < 64) begin
					stage_terms[stage_count] = c.term_in;
					stage_payloads[stage_count] = c.payload_in;
					if (32'(c.element_index) != stage_start + stage_count
							&& stage_err == rls_pkg::BERR_NONE)
						stage_err = rls_pkg::BERR_GAP;
					stage_count++;
				end else if (stage_err == rls_pkg::BERR_NONE) begin
					stage_err = rls_pkg::BERR_OVER;
				end
				if (c.batch_last) begin
					r.status = commit();
					stage_count = 0;
					stage_start = 0;
					stage_err = rls_pkg::BERR_NONE;
				end else begin
					r.status = rls_pkg::STS_STAGED;
				end
			end
			rls_pkg::MODE_READ: begin
				if (c.position >= 1 && c.position <= length) begin
					r.term_out = terms[c.position - 1];
					r.payload_out = payloads[c.position - 1];
					r.status = rls_pkg::STS_OK;
				end
			end
			rls_pkg::MODE_CHECK: begin
				if (c.position == 0) r.status = rls_pkg::STS_OK;
				else if (c.position > length) begin
					r.status = rls_pkg::STS_MISMATCH;
					r.hint_index = 11'(length + 1);
				end else if (terms[c.position - 1] != c.term_in) begin
					idx = 32'(c.position);
					while (idx > 1 && terms[idx - 2] == terms[c.position - 1]) idx--;
					r.status = rls_pkg::STS_MISMATCH;
					r.hint_index = 11'(idx);
				end else r.status = rls_pkg::STS_OK;
			end
			rls_pkg::MODE_TRUNC: begin
				if (c.position >= 1 && c.position <= length) begin
					length = c.position - 1;
					r.status = rls_pkg::STS_OK;
				end
			end
			default: ;
		endcase
		r.last_index = 11'(length);
		r.last_term = length > 0 ? terms[length - 1] : 32'd0;
		pending.push_back(r);
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// Compare a response with the oldest prediction.
	task check_response(rls_pkg::rsp_t r);
		rls_pkg::rsp_t e;
		if (pending.size() == 0) begin
			report("unexpected response", 0, 0);
			return;
		end
		e = pending.pop_front();
		if (r.status != e.status) report("status", r.status, e.status);
		if (r.hint_index != e.hint_index) report("hint_index", r.hint_index, e.hint_index);
		if (r.term_out != e.term_out) report("term_out", r.term_out, e.term_out);
		if (r.payload_out != e.payload_out) report("payload_out", r.payload_out, e.payload_out);
		if (r.last_index != e.last_index) report("last_index", r.last_index, e.last_index);
		if (r.last_term != e.last_term) report("last_term", r.last_term, e.last_term);
	endtask
endclass

module replicated_log_store_tb;
	import rls_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cmd_valid = 0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	rsp_t rsp;

	// Idle odds in percent for each side, and a long receiver hold-off.
	int send_idle = 0;
	int recv_idle = 0;
	int hold_cycles = 0;
	int quiet = 0;
	bit done = 0;
	log_scoreboard sb = new();

	always #10 clk = ~clk;

	replicated_log_store u_top (.*);

	// Check every accepted response; count quiet cycles for the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) sb.check_response(rsp);
			if ((rsp_valid && !rsp_stall) || (cmd_valid && !cmd_stall)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet > 20000) begin
				$display("[replicated_log_store] ERROR");
				$finish;
			end
		end
	end

	// Receiver: random stall, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_stall <= 1;
		end else rsp_stall <= ($urandom_range(99) < recv_idle);
	end

	// Offer one request and hold it until accepted, with random idling first.
	// Valid stays up after acceptance; drain() takes it down, and so does the next call when it idles first.
	task automatic send(cmd_t c);
		while ($urandom_range(99) < send_idle) begin
			cmd_valid <= 0;
			@(posedge clk);
		end
		cmd_valid <= 1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.note_request(c);
	endtask

	task automatic drain();
		cmd_valid <= 0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	function automatic cmd_t make(logic [2:0] m, int p, int e, logic [31:0] t,
			logic [63:0] d, bit l);
		cmd_t c;
		c.mode = m;
		c.position = 11'(p);
		c.element_index = 11'(e);
		c.term_in = t;
		c.payload_in = d;
		c.batch_last = l;
		return c;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// Pick a term, mostly from a small set, so runs of equal terms form.
	function automatic logic [31:0] pick_term();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'hFFFF_FFFF;
			default: return $urandom_range(3);
		endcase
	endfunction

	function automatic int pick_pos();
		int unsigned n;
		n = sb.length;
		case ($urandom_range(7))
			0: return 0;
			1: return n + 1;
			2: return $urandom_range(2047);
			default: return n == 0 ? 0 : $urandom_range(n, 1);
		endcase
	endfunction

	// Send a whole batch starting at start, optionally with a broken index.
	task automatic send_batch(int start, int count, bit broken);
		int bad;
		bad = broken ? $urandom_range(count - 1) : -1;
		for (int i = 0; i < count; i++) begin
			send(make(MODE_BATCH, i == 0 ? start : $urandom_range(2047),
				i == bad ? start + i + 1 : start + i, pick_term(), rnd64(),
				i == count - 1));
			if ($urandom_range(9) == 0) send(make(MODE_READ, pick_pos(), 0, 0, 0, 0));
		end
	endtask

	task automatic random_item();
		int r, n;
		r = $urandom_range(99);
		n = sb.length;
		if (r < 25) send(make(MODE_APPEND, $urandom_range(2047), $urandom_range(2047),
				pick_term(), rnd64(), $urandom_range(1)));
		else if (r < 40) send_batch(n == 0 ? 1 : $urandom_range(n + 1, 1),
				$urandom_range(4, 1), $urandom_range(9) == 0);
		else if (r < 60) send(make(MODE_READ, pick_pos(), $urandom_range(2047),
				$urandom, rnd64(), $urandom_range(1)));
		else if (r < 80) send(make(MODE_CHECK, pick_pos(), 0,
				$urandom_range(1) ? pick_term() : (sb.length > 0 ? sb.terms[$urandom_range(n - 1)]
				: 32'd0), 0, 0));
		else if (r < 88) send(make(MODE_TRUNC, pick_pos(), 0, 0, 0, 0));
		else if (r < 95) send_batch($urandom_range(2047), $urandom_range(3, 1), 0);
		else send(make($urandom_range(7, 5), $urandom_range(2047), $urandom_range(2047),
				$urandom, rnd64(), $urandom_range(1)));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty log, unused modes, extremes.
		send(make(MODE_READ, 1, 0, 0, 0, 0));
		send(make(MODE_CHECK, 0, 0, 32'hFFFF_FFFF, 0, 0));
		send(make(MODE_CHECK, 5, 0, 0, 0, 0));
		send(make(MODE_TRUNC, 0, 0, 0, 0, 0));
		send(make(3'd7, 2047, 2047, 32'hFFFF_FFFF, '1, 1));
		send(make(3'd5, 0, 0, 0, 0, 0));
		send(make(MODE_APPEND, 2047, 2047, 32'hFFFF_FFFF, '1, 1));
		send(make(MODE_APPEND, 0, 0, 1, 0, 0));
		send(make(MODE_APPEND, 0, 0, 1, 64'h5555, 0));
		send(make(MODE_READ, 3, 0, 0, 0, 0));
		send(make(MODE_READ, 1, 0, 0, 0, 0));
		send(make(MODE_CHECK, 3, 0, 2, 0, 0));
		send(make(MODE_CHECK, 2, 0, 1, 0, 0));
		send_batch(0, 2, 0);
		send_batch(5, 1, 0);
		send_batch(2, 3, 1);
		send_batch(3, 3, 0);
		send(make(MODE_TRUNC, 1, 0, 0, 0, 0));
		// Overflowing batch: 65 elements with the last one past the stage.
		send_batch(1, 65, 0);
		drain();

		// Far positions: check beyond the log, batch starting past the end.
		send(make(MODE_CHECK, 1024, 0, 32'hFFFF_FFFE, 0, 0));
		send_batch(1000, 3, 0);
		send(make(MODE_TRUNC, 20, 0, 0, 0, 0));

		// Long receiver hold-off while requests keep coming.
		drain();
		hold_cycles = 300;
		for (int i = 0; i < 12; i++) random_item();
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 51; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 51; end
				3: begin send_idle = 20; recv_idle = 20; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			for (int i = 0; i < 125; i++) random_item();
			// Pause until every response is back.
			drain();
		end
		recv_idle = 0;
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[replicated_log_store] OK");
		end else begin
			$display("[replicated_log_store] ERROR");
		end
		$finish;
	end
endmodule
